### rtl/core/tun_pkg.sv
package tun_pkg;

    // Width of each normal component on the result side
    localparam int OUT_W = 32;

endpackage

### rtl/core/tun_cross.sv
module tun_cross #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [COORD_WIDTH-1:0]          i_ax,
    input  logic [COORD_WIDTH-1:0]          i_ay,
    input  logic [COORD_WIDTH-1:0]          i_az,
    input  logic [COORD_WIDTH-1:0]          i_bx,
    input  logic [COORD_WIDTH-1:0]          i_by,
    input  logic [COORD_WIDTH-1:0]          i_bz,
    input  logic [COORD_WIDTH-1:0]          i_cx,
    input  logic [COORD_WIDTH-1:0]          i_cy,
    input  logic [COORD_WIDTH-1:0]          i_cz,
    output logic                            o_valid,
    output logic [2:0][2*COORD_WIDTH+1:0]   o_mag,
    output logic [2:0]                      o_neg
);

    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int NW = 2 * COORD_WIDTH + 3;
    localparam int M  = 2 * COORD_WIDTH + 2;

    logic [2:0][COORD_WIDTH-1:0] w_a, w_b, w_c;
    logic signed [EW-1:0]        n_e [3];
    logic signed [EW-1:0]        n_f [3];
    logic signed [EW-1:0]        r_e [3];
    logic signed [EW-1:0]        r_f [3];
    logic signed [PW-1:0]        r_p [6];
    logic signed [NW-1:0]        r_n [3];
    logic                        r_v1, r_v2, r_v3;

    assign w_a = {i_az, i_ay, i_ax};
    assign w_b = {i_bz, i_by, i_bx};
    assign w_c = {i_cz, i_cy, i_cx};

    // Form edge vectors B - A and C - A
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e[i] = $signed({w_b[i][COORD_WIDTH-1], w_b[i]})
                   - $signed({w_a[i][COORD_WIDTH-1], w_a[i]});
            n_f[i] = $signed({w_c[i][COORD_WIDTH-1], w_c[i]})
                   - $signed({w_a[i][COORD_WIDTH-1], w_a[i]});
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    // Edges, cross products, differences, magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e[i] <= n_e[i];
                r_f[i] <= n_f[i];
            end
            r_p[0] <= PW'(r_e[1]) * PW'(r_f[2]);
            r_p[1] <= PW'(r_e[2]) * PW'(r_f[1]);
            r_p[2] <= PW'(r_e[2]) * PW'(r_f[0]);
            r_p[3] <= PW'(r_e[0]) * PW'(r_f[2]);
            r_p[4] <= PW'(r_e[0]) * PW'(r_f[1]);
            r_p[5] <= PW'(r_e[1]) * PW'(r_f[0]);
            for (int k = 0; k < 3; k++) begin
                r_n[k]   <= NW'(r_p[2*k]) - NW'(r_p[2*k+1]);
                o_neg[k] <= r_n[k][NW-1];
                o_mag[k] <= M'(r_n[k][NW-1] ? -r_n[k] : r_n[k]);
            end
        end
    end

endmodule

### rtl/core/tun_square.sv
module tun_square #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [2:0][2*COORD_WIDTH+1:0]   i_mag,
    input  logic [2:0]                      i_neg,
    output logic                            o_valid,
    output logic [4*COORD_WIDTH+5:0]        o_sum,
    output logic [2:0][2*COORD_WIDTH+1:0]   o_mag,
    output logic [2:0]                      o_neg
);

    localparam int M  = 2 * COORD_WIDTH + 2;
    localparam int H  = COORD_WIDTH + 1;
    localparam int PW = 2 * H;
    localparam int QW = 2 * M;
    localparam int SW = QW + 2;

    logic [PW-1:0]         r_hh [3];
    logic [PW-1:0]         r_hl [3];
    logic [PW-1:0]         r_lh [3];
    logic [PW-1:0]         r_ll [3];
    logic [QW-1:0]         r_sq [3];
    logic [2:0][M-1:0]     r_mag1, r_mag2;
    logic [2:0]            r_neg1, r_neg2;
    logic                  r_v1, r_v2;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    // Split squares into half-width partial products, then merge and sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= PW'(i_mag[k][M-1:H]) * PW'(i_mag[k][M-1:H]);
                r_hl[k] <= PW'(i_mag[k][M-1:H]) * PW'(i_mag[k][H-1:0]);
                r_lh[k] <= PW'(i_mag[k][H-1:0]) * PW'(i_mag[k][M-1:H]);
                r_ll[k] <= PW'(i_mag[k][H-1:0]) * PW'(i_mag[k][H-1:0]);
                r_sq[k] <= {r_hh[k], r_ll[k]}
                         + (QW'({1'b0, r_hl[k]} + {1'b0, r_lh[k]}) << H);
            end
            o_sum  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_mag1 <= i_mag;
            r_mag2 <= r_mag1;
            o_mag  <= r_mag2;
            r_neg1 <= i_neg;
            r_neg2 <= r_neg1;
            o_neg  <= r_neg2;
        end
    end

endmodule

### rtl/core/tun_isqrt.sv
module tun_isqrt #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [4*COORD_WIDTH+5:0]        i_sum,
    input  logic [2:0][2*COORD_WIDTH+1:0]   i_mag,
    input  logic [2:0]                      i_neg,
    output logic                            o_valid,
    output logic [2*COORD_WIDTH+2:0]        o_root,
    output logic [2:0][2*COORD_WIDTH+1:0]   o_mag,
    output logic [2:0]                      o_neg
);

    localparam int M  = 2 * COORD_WIDTH + 2;
    localparam int RW = 2 * COORD_WIDTH + 3;
    localparam int SW = 2 * RW;

    logic                 r_v    [RW];
    logic [RW-1:0]        r_root [RW];
    logic [RW:0]          r_rem  [RW];
    logic [SW-1:0]        r_s    [RW];
    logic [2:0][M-1:0]    r_mag  [RW];
    logic [2:0]           r_neg  [RW];

    logic                 s_v    [RW];
    logic [RW-1:0]        s_root [RW];
    logic [RW:0]          s_rem  [RW];
    logic [SW-1:0]        s_s    [RW];
    logic [2:0][M-1:0]    s_mag  [RW];
    logic [2:0]           s_neg  [RW];

    // One root bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0] w_x, w_t, w_d;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign s_v[k]    = i_valid;
            assign s_root[k] = '0;
            assign s_rem[k]  = '0;
            assign s_s[k]    = i_sum;
            assign s_mag[k]  = i_mag;
            assign s_neg[k]  = i_neg;
        end else begin : g_next
            assign s_v[k]    = r_v[k-1];
            assign s_root[k] = r_root[k-1];
            assign s_rem[k]  = r_rem[k-1];
            assign s_s[k]    = r_s[k-1];
            assign s_mag[k]  = r_mag[k-1];
            assign s_neg[k]  = r_neg[k-1];
        end

        assign w_x  = {s_rem[k][RW-1:0], s_s[k][SW-1-2*k -: 2]};
        assign w_t  = {s_root[k], 2'b01};
        assign w_ge = (w_x >= w_t);
        assign w_d  = w_x - w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v[k];
            end
            if (i_en) begin
                r_root[k] <= {s_root[k][RW-2:0], w_ge};
                r_rem[k]  <= w_ge ? w_d[RW:0] : w_x[RW:0];
                r_s[k]    <= s_s[k];
                r_mag[k]  <= s_mag[k];
                r_neg[k]  <= s_neg[k];
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_mag   = r_mag[RW-1];
    assign o_neg   = r_neg[RW-1];

endmodule

### rtl/core/tun_div.sv
module tun_div #(
    parameter int COORD_WIDTH   = 24,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [2*COORD_WIDTH+2:0]                i_root,
    input  logic [2:0][2*COORD_WIDTH+1:0]           i_mag,
    input  logic [2:0]                              i_neg,
    output logic                                    o_valid,
    output logic [2:0][tun_pkg::OUT_W-1:0]          o_comp,
    output logic                                    o_degenerate
);

    import tun_pkg::*;

    localparam int RW = 2 * COORD_WIDTH + 3;
    localparam int QB = OUT_FRAC_BITS + 1;

    logic                  r_v    [QB];
    logic [RW-1:0]         r_root [QB];
    logic [2:0][RW-1:0]    r_rem  [QB];
    logic [2:0][QB-1:0]    r_q    [QB];
    logic [2:0]            r_neg  [QB];

    logic                  s_v    [QB];
    logic [RW-1:0]         s_root [QB];
    logic [2:0][RW-1:0]    s_rem  [QB];
    logic [2:0][QB-1:0]    s_q    [QB];
    logic [2:0]            s_neg  [QB];

    // Restoring division, one quotient bit per stage, three lanes
    for (genvar j = 0; j < QB; j++) begin : g_stage
        logic [2:0][RW:0]   w_x;
        logic [2:0][RW:0]   w_d;
        logic [2:0]         w_ge;

        if (j == 0) begin : g_first
            assign s_v[j]    = i_valid;
            assign s_root[j] = i_root;
            assign s_q[j]    = '0;
            assign s_neg[j]  = i_neg;
            for (genvar c = 0; c < 3; c++) begin : g_init
                assign s_rem[j][c] = RW'(i_mag[c]);
                assign w_x[c]      = {1'b0, s_rem[j][c]};
            end
        end else begin : g_next
            assign s_v[j]    = r_v[j-1];
            assign s_root[j] = r_root[j-1];
            assign s_q[j]    = r_q[j-1];
            assign s_neg[j]  = r_neg[j-1];
            assign s_rem[j]  = r_rem[j-1];
            for (genvar c = 0; c < 3; c++) begin : g_shift
                assign w_x[c] = {s_rem[j][c], 1'b0};
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_lane
            assign w_ge[c] = (w_x[c] >= {1'b0, s_root[j]});
            assign w_d[c]  = w_x[c] - {1'b0, s_root[j]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= s_v[j];
            end
            if (i_en) begin
                r_root[j] <= s_root[j];
                r_neg[j]  <= s_neg[j];
                for (int c = 0; c < 3; c++) begin
                    r_rem[j][c] <= w_ge[c] ? w_d[c][RW-1:0] : w_x[c][RW-1:0];
                    r_q[j][c]   <= {s_q[j][c][QB-2:0], w_ge[c]};
                end
            end
        end
    end

    // Clamp, apply sign, zero out a degenerate triangle
    always_comb begin
        logic [QB-1:0]    lim;
        logic [OUT_W-1:0] mag;
        lim          = QB'(1) << OUT_FRAC_BITS;
        o_degenerate = (r_root[QB-1] == '0);
        for (int c = 0; c < 3; c++) begin
            mag = (r_q[QB-1][c] > lim) ? OUT_W'(lim) : OUT_W'(r_q[QB-1][c]);
            if (o_degenerate) begin
                o_comp[c] = '0;
            end else begin
                o_comp[c] = r_neg[QB-1][c] ? -mag : mag;
            end
        end
    end

    assign o_valid = r_v[QB-1];

endmodule

### rtl/core/triangle_unit_normal_unit.sv
// Unit face normal of a triangle, one request per cycle.
// The square root and divider are bit-per-stage chains.
// Throughput: one request per cycle while the result side takes results.
// Reset: synchronous active-low i_rst_n clears all valid bits and the skid.
module triangle_unit_normal_unit #(
    parameter int COORD_WIDTH   = 24,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [COORD_WIDTH-1:0]              i_ax,
    input  logic [COORD_WIDTH-1:0]              i_ay,
    input  logic [COORD_WIDTH-1:0]              i_az,
    input  logic [COORD_WIDTH-1:0]              i_bx,
    input  logic [COORD_WIDTH-1:0]              i_by,
    input  logic [COORD_WIDTH-1:0]              i_bz,
    input  logic [COORD_WIDTH-1:0]              i_cx,
    input  logic [COORD_WIDTH-1:0]              i_cy,
    input  logic [COORD_WIDTH-1:0]              i_cz,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tun_pkg::OUT_W-1:0]    o_nx,
    output logic signed [tun_pkg::OUT_W-1:0]    o_ny,
    output logic signed [tun_pkg::OUT_W-1:0]    o_nz,
    output logic                                o_degenerate
);

    import tun_pkg::*;

    localparam int M  = 2 * COORD_WIDTH + 2;
    localparam int RW = 2 * COORD_WIDTH + 3;
    localparam int SW = 2 * RW;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] comp;
        logic                  degenerate;
    } t_res;

    logic                 w_en;
    logic                 w_cr_v, w_sq_v, w_rt_v, w_dv_v;
    logic [2:0][M-1:0]    w_cr_mag, w_sq_mag, w_rt_mag;
    logic [2:0]           w_cr_neg, w_sq_neg, w_rt_neg;
    logic [SW-1:0]        w_sum;
    logic [RW-1:0]        w_root;
    t_res                 w_res;
    t_res                 r_out, r_skid;
    logic                 r_out_v, r_skid_v;
    logic                 w_take;

    // Freeze the pipeline only while the skid holds a request
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_az    (i_az),
        .i_bx    (i_bx),
        .i_by    (i_by),
        .i_bz    (i_bz),
        .i_cx    (i_cx),
        .i_cy    (i_cy),
        .i_cz    (i_cz),
        .o_valid (w_cr_v),
        .o_mag   (w_cr_mag),
        .o_neg   (w_cr_neg)
    );

    tun_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cr_v),
        .i_mag   (w_cr_mag),
        .i_neg   (w_cr_neg),
        .o_valid (w_sq_v),
        .o_sum   (w_sum),
        .o_mag   (w_sq_mag),
        .o_neg   (w_sq_neg)
    );

    tun_isqrt #(.COORD_WIDTH(COORD_WIDTH)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_sum   (w_sum),
        .i_mag   (w_sq_mag),
        .i_neg   (w_sq_neg),
        .o_valid (w_rt_v),
        .o_root  (w_root),
        .o_mag   (w_rt_mag),
        .o_neg   (w_rt_neg)
    );

    tun_div #(
        .COORD_WIDTH   (COORD_WIDTH),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_rt_v),
        .i_root       (w_root),
        .i_mag        (w_rt_mag),
        .i_neg        (w_rt_neg),
        .o_valid      (w_dv_v),
        .o_comp       (w_res.comp),
        .o_degenerate (w_res.degenerate)
    );

    assign w_take = r_out_v && !i_stall;

    // Output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en && w_dv_v) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
                r_out   <= w_res;
            end else begin
                r_skid_v <= 1'b1;
                r_skid   <= w_res;
            end
        end else if (w_take) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_v;
    assign o_nx         = r_out.comp[0];
    assign o_ny         = r_out.comp[1];
    assign o_nz         = r_out.comp[2];
    assign o_degenerate = r_out.degenerate;

`ifndef SYNTHESIS
    localparam logic signed [OUT_W-1:0] LIM = OUT_W'(1) << OUT_FRAC_BITS;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a request while output is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid filled while output was free");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.degenerate) |-> (o_nx == 0 && o_ny == 0 && o_nz == 0))
        else $error("degenerate result with nonzero components");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.degenerate) |->
            (o_nx <= LIM && o_nx >= -LIM && o_ny <= LIM && o_ny >= -LIM
             && o_nz <= LIM && o_nz >= -LIM))
        else $error("normal component out of range");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int COORD_W    = 24;
    localparam int FRAC_BITS  = 30;
    localparam int OUT_W      = tun_pkg::OUT_W;
    localparam int NUM_RANDOM = 550;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 120;
    localparam int HOLD_LEN   = 300;

    typedef logic [COORD_W-1:0] t_tri [9];

    typedef struct packed {
        logic [OUT_W-1:0] nx;
        logic [OUT_W-1:0] ny;
        logic [OUT_W-1:0] nz;
        logic             degen;
    } t_normal;

    typedef struct {
        t_tri    coords;
        bit      typed;
        t_normal want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [COORD_W-1:0] i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_cx, i_cy, i_cz;
    logic               o_valid;
    logic               i_stall;
    logic signed [OUT_W-1:0] o_nx, o_ny, o_nz;
    logic               o_degenerate;

    t_normal normal_q[$];
    int      err_count;
    int      req_count;
    int      idle_cycles;
    bit      pressured;
    int      hold_left;

    triangle_unit_normal_unit #(
        .COORD_WIDTH  (COORD_W),
        .OUT_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ax        (i_ax),
        .i_ay        (i_ay),
        .i_az        (i_az),
        .i_bx        (i_bx),
        .i_by        (i_by),
        .i_bz        (i_bz),
        .i_cx        (i_cx),
        .i_cy        (i_cy),
        .i_cz        (i_cz),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_nx        (o_nx),
        .o_ny        (o_ny),
        .o_nz        (o_nz),
        .o_degenerate(o_degenerate)
    );

    // Clock: 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Exact face normal: edges, cross product, floored root, scaled quotient
    function automatic t_normal calc_normal(t_tri t);
        longint     a[3], e[3], f[3], cr[3];
        logic [127:0] mag[3], sum, root, cand, num, quo;
        logic [127:0] lim;
        t_normal    r;
        lim = 128'd1 << FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(t[i]));
            e[i] = longint'($signed(t[3+i])) - a[i];
            f[i] = longint'($signed(t[6+i])) - a[i];
        end
        cr[0] = e[1] * f[2] - e[2] * f[1];
        cr[1] = e[2] * f[0] - e[0] * f[2];
        cr[2] = e[0] * f[1] - e[1] * f[0];
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
            sum = sum + mag[i] * mag[i];
        end
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum)
                root = cand;
        end
        r.degen = (root == 0);
        if (r.degen) begin
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            num = mag[i] << FRAC_BITS;
            quo = num / root;
            if (quo > lim)
                quo = lim;
            if (cr[i] < 0)
                quo = -quo;
            case (i)
                0: r.nx = quo[OUT_W-1:0];
                1: r.ny = quo[OUT_W-1:0];
                default: r.nz = quo[OUT_W-1:0];
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Record the expected normal of each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            normal_q.push_back(calc_normal('{i_ax, i_ay, i_az, i_bx, i_by, i_bz,
                                             i_cx, i_cy, i_cz}));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_normal w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (normal_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                err_count++;
            end else begin
                w = normal_q.pop_front();
                if (o_nx !== w.nx) report_mismatch("nx", o_nx, w.nx);
                if (o_ny !== w.ny) report_mismatch("ny", o_ny, w.ny);
                if (o_nz !== w.nz) report_mismatch("nz", o_nz, w.nz);
                if (o_degenerate !== w.degen)
                    report_mismatch("degenerate", 32'(o_degenerate), 32'(w.degen));
            end
        end
    end

    // Watchdog: end the run after too long without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall in changing modes, with one long hold-off
    always @(negedge i_clk) begin
        int mode;
        mode = (int'($realtime) / 1280) % 4;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!pressured && req_count >= 150) begin
            pressured <= 1'b1;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else begin
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // Offer one request, hold it until taken, then maybe open a gap
    task automatic send_request(t_tri t);
        int gap;
        i_valid <= 1'b1;
        i_ax <= t[0]; i_ay <= t[1]; i_az <= t[2];
        i_bx <= t[3]; i_by <= t[4]; i_bz <= t[5];
        i_cx <= t[6]; i_cy <= t[7]; i_cz <= t[8];
        do @(posedge i_clk); while (o_stall);
        req_count++;
        @(negedge i_clk);
        if ($urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] base);
        return base + COORD_W'($urandom_range(0, 2000)) - COORD_W'(1000);
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic t_tri random_tri();
        t_tri t;
        int   kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            t[i] = COORD_W'($urandom);
        for (int i = 0; i < 3; i++) begin
            case (kind)
                4, 5, 6: begin
                    t[3+i] = near(t[i]);
                    t[6+i] = near(t[i]);
                end
                7: begin
                    t[3+i] = near(t[i]);
                    t[6+i] = t[i] + ((t[3+i] - t[i]) << 1);
                end
                8: begin
                    t[i]   = pick_extreme();
                    t[3+i] = pick_extreme();
                    t[6+i] = pick_extreme();
                end
                9: t[6+i] = t[i];
                default: ;
            endcase
        end
        return t;
    endfunction

    localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]   ONE  = OUT_W'(1) << FRAC_BITS;

    t_dir_row dir_rows[] = '{
        // all zero: degenerate
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1}},
        // unit edges along x and y: normal +z
        '{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b1, '{0, 0, ONE, 1'b0}},
        // swapped winding: normal -z
        '{'{0, 0, 0, 0, 1, 0, 1, 0, 0}, 1'b1, '{0, 0, -ONE, 1'b0}},
        // edges along y and z: normal +x
        '{'{0, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b1, '{ONE, 0, 0, 1'b0}},
        // coincident extreme vertices: degenerate
        '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, 1'b1, '{0, 0, 0, 1'b1}},
        '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, '{0, 0, 0, 1'b1}},
        // widest edges
        '{'{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}, 1'b0, '{0, 0, 0, 1'b0}},
        '{'{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, '{0, 0, 0, 1'b0}},
        '{'{CMIN, CMAX, 0, CMAX, CMIN, 0, CMAX, CMAX, CMIN}, 1'b0, '{0, 0, 0, 1'b0}},
        '{'{'1, '1, '1, 0, 0, 0, CMAX, CMIN, '1}, 1'b0, '{0, 0, 0, 1'b0}},
        // collinear vertices: degenerate
        '{'{0, 0, 0, 5, 7, 9, 10, 14, 18}, 1'b1, '{0, 0, 0, 1'b1}},
        // tiny sloped triangle
        '{'{3, -2, 1, 4, -2, 2, 3, -1, 2}, 1'b0, '{0, 0, 0, 1'b0}}
    };

    initial begin
        err_count = 0;
        req_count = 0;
        idle_cycles = 0;
        pressured = 1'b0;
        hold_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        {i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_cx, i_cy, i_cz} = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows; typed rows must also agree with the predictor
        foreach (dir_rows[k]) begin
            t_normal p;
            p = calc_normal(dir_rows[k].coords);
            if (dir_rows[k].typed && p != dir_rows[k].want) begin
                $display("directed row %0d: predictor disagrees with table", k);
                err_count++;
            end
            send_request(dir_rows[k].coords);
        end

        // Random requests in bursts
        for (int n = 0; n < NUM_RANDOM; n++)
            send_request(random_tri());
        i_valid <= 1'b0;

        // Drain, then settle
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/tun_pkg.sv
rtl/core/tun_cross.sv
rtl/core/tun_square.sv
rtl/core/tun_isqrt.sv
rtl/core/tun_div.sv
rtl/core/triangle_unit_normal_unit.sv
tb/tb.sv
